FILE: rtl/lbsr_pkg.sv
// ----------------------------------------------------------------------------
// lbsr_pkg
// Shared types and sizes for the longest bounded-spread run finder.
// ----------------------------------------------------------------------------
package lbsr_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int SPREAD_W    = 16;
    localparam int CMP_W       = SAMPLE_BITS + 2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [CMP_W-1:0]       t_cmp;
    typedef logic        [IDX_W-1:0]       t_idx;
    typedef logic        [CNT_W-1:0]       t_cnt;

    // Per-step command broadcast to every cell.
    typedef struct packed {
        logic    step;
        logic    clr;
        t_sample x;
        t_cmp    lim_hi;
        t_cmp    lim_lo;
        t_idx    idx;
    } t_cmd;

endpackage

FILE: rtl/lbsr_cell.sv
// ----------------------------------------------------------------------------
// lbsr_cell
// One slot of a monotonic deque: holds a sample and its index.
// ----------------------------------------------------------------------------
module lbsr_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_is_min,
    input  lbsr_pkg::t_cmd i_cmd,
    input  logic          i_prev_keep,
    output logic          o_keep,
    input  logic          i_next_far,
    output logic          o_far,
    output lbsr_pkg::t_idx o_cand
);
    import lbsr_pkg::*;

    logic    r_valid;
    t_sample r_val;
    t_idx    r_idx;
    t_cmp    w_v;
    t_cmp    w_x;
    logic    w_pop;
    logic    w_wr;

    assign w_v = t_cmp'(r_val);
    assign w_x = t_cmp'(i_cmd.x);

    // Max deque drops entries not above the new sample, min deque the mirror.
    always_comb begin
        if (i_is_min) begin
            w_pop = (w_v >= w_x);
            o_far = r_valid && (w_v < i_cmd.lim_lo);
        end else begin
            w_pop = (w_v <= w_x);
            o_far = r_valid && (w_v > i_cmd.lim_hi);
        end
    end

    assign o_keep = r_valid && !w_pop;
    assign w_wr   = i_prev_keep && (w_pop || !r_valid);
    // Last far entry in the deque marks where the window must start after.
    assign o_cand = (o_far && !i_next_far) ? t_idx'(r_idx + 1'b1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clr) begin
            r_valid <= 1'b0;
        end else if (i_cmd.step) begin
            if (w_wr) begin
                r_valid <= 1'b1;
            end else if (!i_prev_keep) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_wr) begin
            r_val <= i_cmd.x;
            r_idx <= i_cmd.idx;
        end
    end

endmodule

FILE: rtl/lbsr_deque.sv
// ----------------------------------------------------------------------------
// lbsr_deque
// Row of deque cells, oldest at cell 0, plus the window-start candidate.
// ----------------------------------------------------------------------------
module lbsr_deque (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_is_min,
    input  lbsr_pkg::t_cmd i_cmd,
    output lbsr_pkg::t_idx o_cand
);
    import lbsr_pkg::*;

    logic [MAX_SAMPLES:0]   w_keep;
    logic [MAX_SAMPLES:0]   w_far;
    t_idx                   w_cand [MAX_SAMPLES];

    assign w_keep[0]           = 1'b1;
    assign w_far[MAX_SAMPLES]  = 1'b0;

    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        lbsr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_is_min    (i_is_min),
            .i_cmd       (i_cmd),
            .i_prev_keep (w_keep[g]),
            .o_keep      (w_keep[g+1]),
            .i_next_far  (w_far[g+1]),
            .o_far       (w_far[g]),
            .o_cand      (w_cand[g])
        );
    end

    // At most one cell is a boundary, so an OR picks its index.
    always_comb begin
        o_cand = '0;
        for (int i = 0; i < MAX_SAMPLES; i++) begin
            o_cand = o_cand | w_cand[i];
        end
    end

endmodule

FILE: rtl/longest_bounded_spread_run_unit.sv
// ----------------------------------------------------------------------------
// longest_bounded_spread_run_unit
// Streaming search for the longest run whose spread stays within a limit.
// ----------------------------------------------------------------------------
// Each sample is first captured, then the max and min deque cell rows
// update in place and the window start and best run are refreshed. A
// sample marked last also waits there while an earlier result is still
// held on the output. Up to 1024 samples per sequence are searched;
// later ones are dropped and flagged in overflow. No clearing pass after
// reset. max_spread is register 0 of the APB port.
module longest_bounded_spread_run_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] sample
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [0] found, [10:1] start_index,
                                     // [20:11] end_index, [21] overflow
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import lbsr_pkg::*;

    logic                r_busy;
    t_sample             r_x;
    logic                r_last;
    t_cnt                r_count;
    t_idx                r_start;
    t_idx                r_bs;
    t_idx                r_be;
    logic                r_found;
    logic                r_ovf;
    logic [SPREAD_W-1:0] r_spread;
    logic                r_out_valid;
    logic [23:0]         r_out;

    logic  w_proc;
    logic  w_full;
    t_cmd  w_cmd;
    t_idx  w_cmax;
    t_idx  w_cmin;
    t_idx  w_s;
    t_idx  w_j;
    t_idx  w_len;
    t_idx  w_blen;
    logic  w_upd;
    t_idx  n_bs;
    t_idx  n_be;
    logic  n_found;
    logic  n_ovf;

    assign o_pready   = 1'b1;
    assign o_prdata   = 32'(r_spread);
    assign o_s_tready = !r_busy;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    assign w_proc = r_busy && (!r_last || !r_out_valid || i_m_tready);
    assign w_full = (r_count >= t_cnt'(MAX_SAMPLES));
    assign w_j    = r_count[IDX_W-1:0];

    always_comb begin
        w_cmd.step   = w_proc && !w_full;
        w_cmd.clr    = w_proc && r_last;
        w_cmd.x      = r_x;
        w_cmd.lim_hi = t_cmp'(r_x) + t_cmp'({2'b00, r_spread});
        w_cmd.lim_lo = t_cmp'(r_x) - t_cmp'({2'b00, r_spread});
        w_cmd.idx    = w_j;
    end

    lbsr_deque u_dq_max (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_is_min(1'b0),
        .i_cmd   (w_cmd),
        .o_cand  (w_cmax)
    );

    lbsr_deque u_dq_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_is_min(1'b1),
        .i_cmd   (w_cmd),
        .o_cand  (w_cmin)
    );

    always_comb begin
        w_s = r_start;
        if (w_cmax > w_s) begin
            w_s = w_cmax;
        end
        if (w_cmin > w_s) begin
            w_s = w_cmin;
        end
        w_len  = w_j - w_s;
        w_blen = r_found ? (r_be - r_bs) : '0;
        w_upd  = !w_full && (w_j > w_s) && (w_len > w_blen);
        n_bs    = w_upd ? w_s : r_bs;
        n_be    = w_upd ? w_j : r_be;
        n_found = r_found || w_upd;
        n_ovf   = r_ovf || w_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_start     <= '0;
            r_bs        <= '0;
            r_be        <= '0;
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
            r_spread    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_psel && i_penable && i_pwrite && (i_paddr == 3'd0)) begin
                r_spread <= i_pwdata[SPREAD_W-1:0];
            end
            if (w_proc && r_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_s_tvalid && !r_busy) begin
                r_busy <= 1'b1;
            end else if (w_proc) begin
                r_busy <= 1'b0;
                if (r_last) begin
                    r_count     <= '0;
                    r_start     <= '0;
                    r_bs        <= '0;
                    r_be        <= '0;
                    r_found     <= 1'b0;
                    r_ovf       <= 1'b0;
                end else begin
                    if (!w_full) begin
                        r_count <= r_count + 1'b1;
                        r_start <= w_s;
                    end
                    r_bs    <= n_bs;
                    r_be    <= n_be;
                    r_found <= n_found;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && !r_busy) begin
            r_x    <= i_s_tdata;
            r_last <= i_s_tlast;
        end
        if (w_proc && r_last) begin
            r_out <= {2'b00, n_ovf,
                      n_found ? n_be : t_idx'(0),
                      n_found ? n_bs : t_idx'(0),
                      n_found};
        end
    end

endmodule

FILE: test/longest_bounded_spread_run_unit_tb.sv
// ----------------------------------------------------------------------------
// longest_bounded_spread_run_unit_tb
// Streams sample sequences into the run finder under random stalls and checks
// every reported run against a local sliding-window predictor.
// ----------------------------------------------------------------------------
module longest_bounded_spread_run_unit_tb;
    import lbsr_pkg::*;

    localparam int REG_MAX_SPREAD = 0;
    localparam int IDLE_LIMIT     = 20000;

    typedef struct packed {
        logic    last;
        t_sample sample;
    } t_item;

    typedef struct packed {
        logic found;
        t_idx start_index;
        t_idx end_index;
        logic overflow;
    } t_run;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    longest_bounded_spread_run_unit dut (.*);

    // predictor state
    int unsigned spread_lim;
    int unsigned n_stored;
    int unsigned win_lo;
    int          hist[MAX_SAMPLES];
    int unsigned run_lo, run_hi;
    bit          run_ok;
    bit          dropped;

    t_item  item_q[$];
    t_run   run_q[$];
    int     n_fail;
    int     n_sent;
    int     n_runs;
    int     idle_cycles;
    int     send_gap;
    int     recv_gap;
    bit     hold_send;
    bit     in_taken;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        n_fail++;
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sliding-window search, one sample at a time.
    task automatic predict_run(input t_item it);
        int          x;
        int          d;
        int unsigned j;
        int unsigned s;
        t_run        r;
        x = it.sample;
        if (n_stored >= MAX_SAMPLES) begin
            dropped = 1'b1;
        end else begin
            j = n_stored;
            s = win_lo;
            for (int unsigned k = j; k > win_lo; k--) begin
                d = hist[k-1] - x;
                if (d < 0) d = -d;
                if (d > int'(spread_lim)) begin
                    s = k;
                    break;
                end
            end
            hist[j] = x;
            win_lo = s;
            if (j > s && (j - s) > (run_ok ? run_hi - run_lo : 0)) begin
                run_lo = s;
                run_hi = j;
                run_ok = 1'b1;
            end
            n_stored = j + 1;
        end
        if (it.last) begin
            r.found       = run_ok;
            r.start_index = run_ok ? t_idx'(run_lo) : '0;
            r.end_index   = run_ok ? t_idx'(run_hi) : '0;
            r.overflow    = dropped;
            run_q = {run_q, r};
            n_stored = 0; win_lo = 0; run_lo = 0; run_hi = 0;
            run_ok = 1'b0; dropped = 1'b0;
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && !in_taken) begin
                // hold the current transfer
            end else if (send_gap > 0) begin
                i_s_tvalid <= 1'b0;
                send_gap--;
            end else if (item_q.size() > 0 && !hold_send) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= item_q[0].sample;
                i_s_tlast  <= item_q[0].last;
                item_q.pop_front();
                send_gap = rand_gap();
            end else begin
                i_s_tvalid <= 1'b0;
            end
            if (recv_gap > 0) begin
                i_m_tready <= 1'b0;
                recv_gap--;
            end else begin
                i_m_tready <= 1'b1;
                recv_gap = rand_gap();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_run got, want;
        if (i_rst_n) begin
            idle_cycles++;
            in_taken = i_s_tvalid && o_s_tready;
            if (in_taken) begin
                predict_run(t_item'({i_s_tlast, i_s_tdata}));
                n_sent++;
                idle_cycles = 0;
            end
            if (o_m_tvalid && i_m_tready) begin
                idle_cycles = 0;
                got = t_run'({o_m_tdata[0], o_m_tdata[10:1], o_m_tdata[20:11],
                              o_m_tdata[21]});
                if (run_q.size() == 0) begin
                    report_mismatch("unexpected result count", 1, 0);
                end else begin
                    want = run_q.pop_front();
                    n_runs++;
                    if (got.found != want.found)
                        report_mismatch("found", got.found, want.found);
                    if (got.start_index != want.start_index)
                        report_mismatch("start_index", got.start_index, want.start_index);
                    if (got.end_index != want.end_index)
                        report_mismatch("end_index", got.end_index, want.end_index);
                    if (got.overflow != want.overflow)
                        report_mismatch("overflow", got.overflow, want.overflow);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("longest_bounded_spread_run_unit test failed");
                $finish;
            end
        end
    end

    task automatic apb_write(input int idx, input logic [31:0] val);
        @(negedge i_clk);
        i_psel <= 1'b1; i_pwrite <= 1'b1; i_penable <= 1'b0;
        i_paddr <= 3'(4 * idx); i_pwdata <= val;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        if (idx == REG_MAX_SPREAD) spread_lim = val[15:0];
        @(negedge i_clk);
        i_psel <= 1'b0; i_penable <= 1'b0; i_pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (item_q.size() > 0 || i_s_tvalid || run_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic push_seq(input int len, input int lo, input int hi, input bit walk);
        t_item it;
        int    v;
        v = $urandom_range(lo, hi);
        for (int i = 0; i < len; i++) begin
            if (walk) begin
                v += $signed($urandom_range(0, 8)) - 4;
                if (v > hi) v = hi;
                if (v < lo) v = lo;
            end else begin
                v = $urandom_range(0, hi - lo) + lo;
            end
            it.sample = t_sample'(v);
            it.last   = (i == len - 1);
            item_q = {item_q, it};
        end
    endtask

    task automatic push_one(input int v, input bit lst);
        t_item it;
        it.sample = t_sample'(v);
        it.last   = lst;
        item_q = {item_q, it};
    endtask

    initial begin
        int len;
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tlast = 1'b0;
        i_m_tready = 1'b0; i_psel = 1'b0; i_penable = 1'b0; i_pwrite = 1'b0;
        i_paddr = '0; i_pwdata = '0;
        spread_lim = 0; n_stored = 0; win_lo = 0; run_lo = 0; run_hi = 0;
        run_ok = 0; dropped = 0; n_fail = 0; n_sent = 0; n_runs = 0;
        idle_cycles = 0; send_gap = 0; recv_gap = 0; hold_send = 0; in_taken = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, spread 0 (reset value): equal pairs, extremes, short runs
        push_one(5, 1'b1);                       // single sample
        push_one(-32768, 1'b0); push_one(-32768, 1'b0);
        push_one(32767, 1'b0); push_one(32767, 1'b1);
        push_one(1, 1'b0); push_one(2, 1'b0); push_one(3, 1'b1);   // no run
        wait_drained();
        apb_write(REG_MAX_SPREAD, 32'h0000_FFFF);
        push_one(-32768, 1'b0); push_one(32767, 1'b0); push_one(0, 1'b1);
        push_one(-1, 1'b0); push_one(21845, 1'b0); push_one(-21846, 1'b1);
        wait_drained();
        apb_write(REG_MAX_SPREAD, 32'd3);
        push_one(0, 1'b0); push_one(3, 1'b0); push_one(9, 1'b0);
        push_one(12, 1'b0); push_one(10, 1'b0); push_one(100, 1'b1);
        wait_drained();

        // beyond capacity: full sequence plus dropped samples
        apb_write(REG_MAX_SPREAD, 32'd40);
        push_seq(MAX_SAMPLES + 3, -300, 300, 1'b1);
        wait_drained();

        // random phases, mostly short sequences
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apb_write(REG_MAX_SPREAD, 32'd0);
                1: apb_write(REG_MAX_SPREAD, 32'hFFFF);
                default: apb_write(REG_MAX_SPREAD, $urandom_range(0, 60));
            endcase
            for (int s = 0; s < 8; s++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 20);
                if ($urandom_range(0, 3) == 0) push_seq(len, -32768, 32767, 1'b0);
                else push_seq(len, -100, 100, 1'b1);
            end
            if (ph == 4) begin
                hold_send = 1'b1;
                while (run_q.size() > 0 || i_s_tvalid) @(posedge i_clk);
                hold_send = 1'b0;
            end
            wait_drained();
        end

        $display("covered %0d samples in %0d sequences, spreads 0 to 65535, overflow",
                 n_sent, n_runs);
        if (n_fail == 0 && run_q.size() == 0)
            $display("longest_bounded_spread_run_unit test passed");
        else
            $display("longest_bounded_spread_run_unit test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/lbsr_pkg.sv
rtl/lbsr_cell.sv
rtl/lbsr_deque.sv
rtl/longest_bounded_spread_run_unit.sv
test/longest_bounded_spread_run_unit_tb.sv
